// File: hdl/iois_pkg.sv
// Package for the insertion-ordered integer set: sizes, request kinds and
// the command/status structs between controller and datapath. No dependencies.
package iois_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int SLOT_W   = 5;
    localparam int MCNT_W   = 6;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic load;     // item accepted: capture it, restart the walk
        logic rd_srch;  // read member at walk index
        logic cmp;      // compare read member against the value
        logic rd_shf;   // read member one past walk index
        logic wr_shf;   // write it back one place lower, advance
        logic finish;   // commit count/append, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic srch_end;   // clear, or walk reached count
        logic match;      // read member equals the value
        logic is_remove;
        logic shf_end;    // no later member left to move
        logic rsp_free;   // result register can take a new item
    } t_sts;

endpackage

// File: hdl/iois_if.sv
// Valid/ready channels for requests and results of the integer set.
// Depends on iois_pkg.
interface iois_req_if;
    import iois_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

interface iois_rsp_if;
    import iois_pkg::*;
    logic              valid;
    logic              ready;
    logic              done_res;
    logic              was_member;
    logic              full_error;
    logic [SLOT_W-1:0] slot;
    logic [MCNT_W-1:0] member_count;

    modport source (output valid, done_res, was_member, full_error, slot, member_count,
                    input ready);
    modport sink   (input valid, done_res, was_member, full_error, slot, member_count,
                    output ready);
endinterface

// File: hdl/iois_ctrl.sv
// Sequencer for the set: search walk, compacting shift, result hand-off.
// Depends on iois_pkg.
module iois_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  iois_pkg::t_sts i_sts,
    output iois_pkg::t_cmd o_cmd
);
    import iois_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SRCH_RD  = 6'b000010,
        S_SRCH_CMP = 6'b000100,
        S_SHF_RD   = 6'b001000,
        S_SHF_WR   = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_sts.srch_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_srch = 1'b1;
                    n_state       = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.match) begin
                    n_state = i_sts.is_remove ? S_SHF_RD : S_DONE;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SHF_RD: begin
                if (i_sts.shf_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_shf = 1'b1;
                    n_state      = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                o_cmd.wr_shf = 1'b1;
                n_state      = S_SHF_RD;
            end
            S_DONE: begin
                if (i_sts.rsp_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/iois_dpath.sv
// Datapath of the set: member memory, count, walk index, result register.
// Depends on iois_pkg and iois_if.
module iois_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    iois_req_if.sink       i_req,
    iois_rsp_if.source     o_rsp,
    input  iois_pkg::t_cmd i_cmd,
    output iois_pkg::t_sts o_sts
);
    import iois_pkg::*;

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rd_data;

    t_kind            r_kind;
    logic [VAL_W-1:0] r_value;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pos;
    logic             r_found;

    logic              r_out_vld;
    logic              r_out_done;
    logic              r_out_was;
    logic              r_out_full;
    logic [SLOT_W-1:0] r_out_slot;
    logic [MCNT_W-1:0] r_out_cnt;

    logic [CNT_W-1:0] idx_nxt;
    logic             set_full;
    logic             add_ok;
    logic             rem_ok;
    logic             done_res;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;

    assign idx_nxt  = r_idx + CNT_W'(1);
    assign set_full = (r_count == CNT_W'(CAPACITY));
    assign add_ok   = (r_kind == KIND_ADD) && !r_found && !set_full;
    assign rem_ok   = (r_kind == KIND_REMOVE) && r_found;
    assign done_res = add_ok || rem_ok || ((r_kind == KIND_LOOKUP) && r_found);

    always_comb begin
        case (r_kind)
            KIND_CLEAR:  n_count = '0;
            KIND_ADD:    n_count = add_ok ? r_count + CNT_W'(1) : r_count;
            KIND_REMOVE: n_count = rem_ok ? r_count - CNT_W'(1) : r_count;
            default:     n_count = r_count;
        endcase
    end

    // one write port: shift write-back, or append on finish
    assign wr_en   = i_cmd.wr_shf || (i_cmd.finish && add_ok);
    assign wr_addr = i_cmd.wr_shf ? r_idx[IDX_W-1:0] : r_count[IDX_W-1:0];
    assign wr_data = i_cmd.wr_shf ? r_rd_data : r_value;
    assign rd_addr = i_cmd.rd_shf ? idx_nxt[IDX_W-1:0] : r_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_srch || i_cmd.rd_shf) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_req.kind);
            r_value <= i_req.value;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_cmd.cmp) begin
            if (r_rd_data == r_value) begin
                r_found <= 1'b1;
                r_pos   <= r_idx[IDX_W-1:0];
            end else begin
                r_idx <= idx_nxt;
            end
        end else if (i_cmd.wr_shf) begin
            r_idx <= idx_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_done <= done_res;
            r_out_was  <= r_found;
            r_out_full <= (r_kind == KIND_ADD) && !r_found && set_full;
            r_out_slot <= SLOT_W'(r_pos);
            r_out_cnt  <= MCNT_W'(n_count);
        end
    end

    assign o_sts.srch_end  = (r_kind == KIND_CLEAR) || (r_idx == r_count);
    assign o_sts.match     = (r_rd_data == r_value);
    assign o_sts.is_remove = (r_kind == KIND_REMOVE);
    assign o_sts.shf_end   = (idx_nxt >= r_count);
    assign o_sts.rsp_free  = !r_out_vld || o_rsp.ready;

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.done_res     = r_out_done;
    assign o_rsp.was_member   = r_out_was;
    assign o_rsp.full_error   = r_out_full;
    assign o_rsp.slot         = r_out_slot;
    assign o_rsp.member_count = r_out_cnt;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("member count above capacity");

    a_count_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> $past(i_cmd.finish))
        else $error("member count changed outside finish");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_shf |-> (idx_nxt < r_count))
        else $error("shift write beyond last member");

    a_rsp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_full && (r_out_done || r_out_was)))
        else $error("full error reported together with success or membership");

endmodule

// File: hdl/insertion_ordered_integer_set_core.sv
// Insertion-ordered integer set, top level: controller plus datapath.
// Each member searched or moved takes a read, then a compare or write state; a last
// read state ends the walk, and S_DONE registers the result once the result register
// is free. Longest: absent value on a full set, remove of slot 0. One item at a time;
// the next is taken the cycle after a result is registered, while it may still wait.
// Reset: member count zero, result register empty; member memory is not cleared.
module insertion_ordered_integer_set_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iois_req_if.sink   i_req,
    iois_rsp_if.source o_rsp
);
    import iois_pkg::*;

    t_cmd cmd;
    t_sts sts;

    iois_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    iois_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
